[rtl/csm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package csm_pkg;

  // Input field widths
  localparam int KIND_W  = 2;
  localparam int INDEX_W = 10;
  localparam int VALUE_W = 32;

  // Result field widths
  localparam int ROW_W = 16;
  localparam int SUM_W = 64;

  // Dense vector store
  localparam int VEC_DEPTH = 1024;
  localparam int VEC_AW    = $clog2(VEC_DEPTH);

  // Command queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // Item kind codes on the input port
  localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NONZERO = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd2;

  // Saturation limits of the Q16.48 accumulator
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_MAC,
    OP_EMPTY
  } op_t;

  // One classified command
  typedef struct packed {
    op_t                op;
    logic [VEC_AW-1:0]  addr;
    logic               in_range;
    logic [VALUE_W-1:0] value;
    logic               last;
  } cmd_t;

  // Queue status seen by the front
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

`default_nettype wire

[rtl/csm_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module csm_front (
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [csm_pkg::KIND_W-1:0]  in_kind,
  input  wire logic [csm_pkg::INDEX_W-1:0] in_index,
  input  wire logic [csm_pkg::VALUE_W-1:0] in_value,
  input  wire logic                        in_row_end,
  input  wire csm_pkg::qstat_t             q_stat,
  output logic                             push,
  output csm_pkg::cmd_t                    cmd
);
  import csm_pkg::*;

  logic known;

  // Decode kind; the unused code is dropped on accept
  always_comb begin
    cmd.op   = OP_LOAD;
    known    = 1'b1;
    case (in_kind)
      KIND_LOAD:    cmd.op = OP_LOAD;
      KIND_NONZERO: cmd.op = OP_MAC;
      KIND_EMPTY:   cmd.op = OP_EMPTY;
      default:      known  = 1'b0;
    endcase
    cmd.addr     = VEC_AW'(in_index);
    cmd.in_range = (32'(in_index) < VEC_DEPTH);
    cmd.value    = in_value;
    cmd.last     = in_row_end;
  end

  // Take a beat whenever the queue has room
  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full && known;

endmodule

`default_nettype wire

[rtl/csm_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module csm_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire csm_pkg::cmd_t push_data,
  input  wire logic          pop,
  output csm_pkg::cmd_t      head,
  output csm_pkg::qstat_t    q_stat
);
  import csm_pkg::*;

  cmd_t            slot_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]   count_r, count_nxt;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign head         = slot_r[rd_ptr_r];
  assign q_stat.full  = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign q_stat.empty = (count_r == '0);

endmodule

`default_nettype wire

[rtl/csm_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module csm_back (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire csm_pkg::qstat_t                  q_stat,
  input  wire csm_pkg::cmd_t                    head,
  output logic                                  pop,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic        [csm_pkg::ROW_W-1:0]      out_row_number,
  output logic signed [csm_pkg::SUM_W-1:0]      out_row_sum,
  output logic                                  out_saturated
);
  import csm_pkg::*;

  logic [VALUE_W-1:0] vec_mem [VEC_DEPTH];

  logic               adv;
  // stage 1: vector read
  logic               s1_valid_r;
  cmd_t               s1_cmd_r;
  logic [VALUE_W-1:0] rd_r;
  // stage 2: product
  logic               s2_valid_r;
  op_t                s2_op_r;
  logic               s2_last_r;
  logic signed [SUM_W-1:0] s2_prod_r;
  logic signed [SUM_W-1:0] prod_nxt;
  logic signed [VALUE_W-1:0] x_op;
  // stage 3: accumulator and result register
  logic signed [SUM_W-1:0] acc_r, acc_nxt;
  logic                    clip_r, clip_nxt;
  logic [ROW_W-1:0]        row_r, row_nxt;
  logic signed [SUM_W-1:0] sum_raw;
  logic signed [SUM_W-1:0] sum_sat;
  logic                    ovf;
  logic                    emit;
  logic                    out_valid_r, out_valid_nxt;
  logic [ROW_W-1:0]        out_row_r, out_row_nxt;
  logic signed [SUM_W-1:0] out_sum_r, out_sum_nxt;
  logic                    out_sat_r, out_sat_nxt;

  // Whole pipe moves unless a result sits stalled
  assign adv = !(out_valid_r && out_stall);
  assign pop = adv && !q_stat.empty;

  // Stage 1: loads write the store, every command reads it
  always_ff @(posedge clk) begin
    if (pop) begin
      if (head.op == OP_LOAD && head.in_range) begin
        vec_mem[head.addr] <= head.value;
      end
      rd_r     <= vec_mem[head.addr];
      s1_cmd_r <= head;
    end
  end

  // Stage 2: exact 32x32 product; out-of-range column reads as zero
  assign x_op     = s1_cmd_r.in_range ? $signed(rd_r) : '0;
  assign prod_nxt = SUM_W'($signed(s1_cmd_r.value)) * SUM_W'(x_op);

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_op_r   <= s1_cmd_r.op;
      s2_last_r <= s1_cmd_r.last;
      s2_prod_r <= prod_nxt;
    end
  end

  // Stage 3: saturating accumulate and row close
  always_comb begin
    sum_raw = acc_r + s2_prod_r;
    ovf     = (acc_r[SUM_W-1] == s2_prod_r[SUM_W-1]) &&
              (sum_raw[SUM_W-1] != acc_r[SUM_W-1]);
    sum_sat = ovf ? (acc_r[SUM_W-1] ? SUM_MIN : SUM_MAX) : sum_raw;

    acc_nxt       = acc_r;
    clip_nxt      = clip_r;
    row_nxt       = row_r;
    emit          = 1'b0;
    out_row_nxt   = out_row_r;
    out_sum_nxt   = out_sum_r;
    out_sat_nxt   = out_sat_r;

    if (s2_valid_r) begin
      case (s2_op_r)
        OP_MAC: begin
          if (s2_last_r) begin
            emit        = 1'b1;
            out_sum_nxt = sum_sat;
            out_sat_nxt = clip_r || ovf;
            acc_nxt     = '0;
            clip_nxt    = 1'b0;
          end else begin
            acc_nxt  = sum_sat;
            clip_nxt = clip_r || ovf;
          end
        end
        OP_EMPTY: begin
          emit        = 1'b1;
          out_sum_nxt = '0;
          out_sat_nxt = 1'b0;
          acc_nxt     = '0;
          clip_nxt    = 1'b0;
        end
        default: ;
      endcase
    end

    if (emit) begin
      out_row_nxt = row_r;
      row_nxt     = row_r + 1'b1;
    end
    out_valid_nxt = emit;
  end

  // Control and accumulator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      clip_r      <= 1'b0;
      row_r       <= '0;
    end else if (adv) begin
      s1_valid_r  <= pop;
      s2_valid_r  <= s1_valid_r && (s1_cmd_r.op != OP_LOAD);
      out_valid_r <= out_valid_nxt;
      acc_r       <= acc_nxt;
      clip_r      <= clip_nxt;
      row_r       <= row_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (adv) begin
      out_row_r <= out_row_nxt;
      out_sum_r <= out_sum_nxt;
      out_sat_r <= out_sat_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_row_number = out_row_r;
  assign out_row_sum    = out_sum_r;
  assign out_saturated  = out_sat_r;

endmodule

`default_nettype wire

[rtl/csr_sparse_matvec.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake           Beat contents
// in_      input      in_valid/in_stall   kind, index, value, row_end
// out_     output     out_valid/out_stall row_number, row_sum, saturated
//
// Sustains one beat per cycle while no stalled result holds the back pipe; a result passes the
// queue, the vector read, the product and the accumulate. Throughput is set by the saturating
// accumulate and the one store port. Reset (rst_n low, synchronous) clears the queue, the pipe,
// the accumulator and the row count; the vector store holds garbage until each entry is loaded.
// A stalled result freezes the whole back pipe; the four-entry queue then fills and in_stall rises.

module csr_sparse_matvec (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic        [csm_pkg::KIND_W-1:0]  in_kind,
  input  wire logic        [csm_pkg::INDEX_W-1:0] in_index,
  input  wire logic signed [csm_pkg::VALUE_W-1:0] in_value,
  input  wire logic                               in_row_end,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic             [csm_pkg::ROW_W-1:0]   out_row_number,
  output logic signed      [csm_pkg::SUM_W-1:0]   out_row_sum,
  output logic                                    out_saturated
);
  import csm_pkg::*;

  qstat_t q_stat;
  cmd_t   push_cmd;
  cmd_t   head;
  logic   push;
  logic   pop;

  // Front: classify and enqueue
  csm_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_kind    (in_kind),
    .in_index   (in_index),
    .in_value   (in_value),
    .in_row_end (in_row_end),
    .q_stat     (q_stat),
    .push       (push),
    .cmd        (push_cmd)
  );

  csm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_cmd),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  // Back: store, multiply, accumulate
  csm_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_stat         (q_stat),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_row_number (out_row_number),
    .out_row_sum    (out_row_sum),
    .out_saturated  (out_saturated)
  );

  // Checks
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("push into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from an empty queue");

  a_unused_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_kind != KIND_LOAD && in_kind != KIND_NONZERO &&
     in_kind != KIND_EMPTY) |-> !push)
    else $error("unused kind entered the queue");

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import csm_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic signed [VALUE_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] Q_ONE = 32'sh0100_0000;
  localparam int RANDOM_BEATS = 450;

  // One input beat; a drain entry is no beat but a hold until all sums are back
  typedef struct {
    logic [KIND_W-1:0]         kind;
    logic [INDEX_W-1:0]        index;
    logic signed [VALUE_W-1:0] value;
    logic                      row_end;
    logic                      drain;
  } beat_t;

  typedef struct {
    logic [ROW_W-1:0]        row;
    logic signed [SUM_W-1:0] sum;
    logic                    clipped;
  } row_sum_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [KIND_W-1:0] in_kind = KIND_LOAD;
  logic [INDEX_W-1:0] in_index = '0;
  logic signed [VALUE_W-1:0] in_value = '0;
  logic in_row_end = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ROW_W-1:0] out_row_number;
  logic signed [SUM_W-1:0] out_row_sum;
  logic out_saturated;

  csr_sparse_matvec i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_index       (in_index),
    .in_value       (in_value),
    .in_row_end     (in_row_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_row_number (out_row_number),
    .out_row_sum    (out_row_sum),
    .out_saturated  (out_saturated)
  );

  always #6 clk = ~clk;

  beat_t    pending[$];
  row_sum_t sums_due[$];
  int       err_count = 0;
  int       total_beats = 0;
  int       beats_taken = 0;

  // Shadow of the block state
  logic signed [VALUE_W-1:0] vec_copy [VEC_DEPTH];
  logic signed [SUM_W-1:0]   acc_copy = '0;
  logic                      clip_copy = 1'b0;
  logic [ROW_W-1:0]          row_copy = '0;

  // Generator side bookkeeping: which entries hold a loaded value
  logic                 loaded [VEC_DEPTH];
  logic [INDEX_W-1:0]   loaded_cols[$];

  task automatic report_mismatch(input string msg);
    err_count++;
    $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  task automatic close_row(input logic signed [SUM_W-1:0] sum, input logic clipped);
    row_sum_t r;
    r.row = row_copy;
    r.sum = sum;
    r.clipped = clipped;
    sums_due.push_back(r);
    row_copy = row_copy + 1'b1;
    acc_copy = '0;
    clip_copy = 1'b0;
  endtask

  // Row sum predictor: exact Q16.48 product, saturating accumulate
  task automatic predict_row_sum(input beat_t b);
    logic signed [SUM_W-1:0] a64, x64, prod, s;
    case (b.kind)
      KIND_LOAD: vec_copy[b.index] = b.value;
      KIND_NONZERO: begin
        // column always fits the store: the index port is exactly as wide as its address
        a64 = b.value;
        x64 = vec_copy[b.index];
        prod = a64 * x64;
        s = acc_copy + prod;
        if (acc_copy[SUM_W-1] == prod[SUM_W-1] && s[SUM_W-1] != acc_copy[SUM_W-1]) begin
          s = acc_copy[SUM_W-1] ? SUM_MIN : SUM_MAX;
          clip_copy = 1'b1;
        end
        acc_copy = s;
        if (b.row_end) close_row(acc_copy, clip_copy);
      end
      KIND_EMPTY: close_row('0, 1'b0);
      default: ;
    endcase
  endtask

  task automatic check_row_sum();
    row_sum_t want;
    if (sums_due.size() == 0) begin
      report_mismatch($sformatf("unexpected row %0d sum %h", out_row_number, out_row_sum));
    end else begin
      want = sums_due.pop_front();
      if (out_row_number !== want.row)
        report_mismatch($sformatf("row number got %0d want %0d", out_row_number, want.row));
      if (out_row_sum !== want.sum)
        report_mismatch($sformatf("row %0d sum got %h want %h", want.row, out_row_sum,
                                  want.sum));
      if (out_saturated !== want.clipped)
        report_mismatch($sformatf("row %0d saturated got %b want %b", want.row,
                                  out_saturated, want.clipped));
    end
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] m;
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 4))
          0: return Q_MIN;
          1: return Q_MAX;
          2: return -1;
          3: return 0;
          default: return Q_ONE;
        endcase
      end
      2: begin
        m = $urandom_range(32'h4000_0000, 32'h7FFF_FFFF);
        return $urandom_range(0, 1) ? m : -m;
      end
      default: return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
    endcase
  endfunction

  task automatic add_beat(input logic [KIND_W-1:0] k, input logic [INDEX_W-1:0] idx,
                          input logic signed [VALUE_W-1:0] v, input logic e);
    beat_t b;
    b.kind = k;
    b.index = idx;
    b.value = v;
    b.row_end = e;
    b.drain = 1'b0;
    pending.push_back(b);
    total_beats++;
    if (k == KIND_LOAD && !loaded[idx]) begin
      loaded[idx] = 1'b1;
      loaded_cols.push_back(idx);
    end
  endtask

  task automatic add_drain();
    beat_t b;
    b.kind = KIND_LOAD;
    b.index = '0;
    b.value = '0;
    b.row_end = 1'b0;
    b.drain = 1'b1;
    pending.push_back(b);
  endtask

  function automatic logic [INDEX_W-1:0] any_loaded_col();
    return loaded_cols[$urandom_range(0, loaded_cols.size() - 1)];
  endfunction

  // Driver: bursts of beats with random gaps; a stalled beat holds still
  beat_t cur_beat;
  int    gap_left = 0;
  int    burst_left = 1;
  logic  next_valid;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
      burst_left = 1;
    end else begin
      if (in_valid && !in_stall) begin
        predict_row_sum(cur_beat);
        beats_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (pending.size() > 0 && pending[0].drain && sums_due.size() == 0)
          void'(pending.pop_front());
        next_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending.size() > 0 && !pending[0].drain) begin
          cur_beat = pending.pop_front();
          next_valid = 1'b1;
          in_kind <= cur_beat.kind;
          in_index <= cur_beat.index;
          in_value <= cur_beat.value;
          in_row_end <= cur_beat.row_end;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end
        end
        in_valid <= next_valid;
      end
    end
  end

  // Monitor: own stall pattern, long free stretches now and then
  int   stall_left = 0;
  logic stall_now = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_now = 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) check_row_sum();
      if (stall_left > 0) begin
        stall_left--;
      end else begin
        stall_now = !stall_now;
        if (stall_now) stall_left = $urandom_range(0, 5);
        else stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(0, 10);
      end
      out_stall <= stall_now;
    end
  end

  // Stimulus and end of run
  initial begin : stim_proc
    int made;
    int n;
    int sel;
    for (int i = 0; i < VEC_DEPTH; i++) loaded[i] = 1'b0;

    // extremes of the vector store and a few plain entries
    add_beat(KIND_LOAD, 10'd0, Q_MIN, 1'b0);
    add_beat(KIND_LOAD, 10'd1023, Q_MAX, 1'b1);     // row end on a load is ignored
    add_beat(KIND_LOAD, 10'd1, Q_ONE, 1'b0);
    add_beat(KIND_LOAD, 10'd2, 32'sd0, 1'b0);
    add_beat(KIND_NONZERO, 10'd1, Q_ONE, 1'b1);     // 1.0 * 1.0
    // two min*min products clip high
    add_beat(KIND_NONZERO, 10'd0, Q_MIN, 1'b0);
    add_beat(KIND_NONZERO, 10'd0, Q_MIN, 1'b1);
    // three max*min products clip low
    add_beat(KIND_NONZERO, 10'd0, Q_MAX, 1'b0);
    add_beat(KIND_NONZERO, 10'd0, Q_MAX, 1'b0);
    add_beat(KIND_NONZERO, 10'd0, Q_MAX, 1'b1);
    add_beat(KIND_EMPTY, 10'd1023, Q_MIN, 1'b1);    // row end on an empty row is ignored
    add_beat(KIND_UNUSED, 10'd1023, Q_MAX, 1'b1);
    // unfinished row is dropped by the empty row
    add_beat(KIND_NONZERO, 10'd1023, Q_MAX, 1'b0);
    add_beat(KIND_EMPTY, 10'd0, 32'sd0, 1'b0);
    add_beat(KIND_NONZERO, 10'd2, -32'sd1, 1'b1);   // zero vector entry
    add_beat(KIND_NONZERO, 10'd1023, Q_MAX, 1'b1);
    // clip high, then pull back down: flag stays for the row
    add_beat(KIND_NONZERO, 10'd0, Q_MIN, 1'b0);
    add_beat(KIND_NONZERO, 10'd0, Q_MIN, 1'b0);
    add_beat(KIND_NONZERO, 10'd1023, Q_MIN, 1'b1);
    add_drain();

    // random rows over loaded columns, with loads, noise and broken rows
    made = 0;
    while (made < RANDOM_BEATS) begin
      sel = $urandom_range(0, 99);
      if (sel < 15) begin
        add_beat(KIND_LOAD, INDEX_W'($urandom), pick_value(), ($urandom_range(0, 3) == 0));
        made++;
      end else if (sel < 80) begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
          add_beat(KIND_NONZERO, any_loaded_col(), pick_value(), (i == n - 1));
        made += n;
      end else if (sel < 88) begin
        add_beat(KIND_EMPTY, INDEX_W'($urandom), $urandom, 1'($urandom));
        made++;
      end else if (sel < 94) begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
          add_beat(KIND_NONZERO, any_loaded_col(), pick_value(), 1'b0);
        add_beat(KIND_EMPTY, INDEX_W'($urandom), $urandom, 1'($urandom));
        made += n + 1;
      end else if (sel < 98) begin
        add_beat(KIND_UNUSED, INDEX_W'($urandom), $urandom, 1'($urandom));
      end else begin
        add_drain();
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (beats_taken != total_beats) @(posedge clk);
    while (sums_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

[files.f]
rtl/csm_pkg.sv
rtl/csm_front.sv
rtl/csm_queue.sv
rtl/csm_back.sv
rtl/csr_sparse_matvec.sv
tb/testbench.sv
